[src/dlss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlss_pkg: shared types and constants of the dipolar lattice shell sum
// Transaction payloads, request and register codes, fixed-point constants.
// ----------------------------------------------------------------------------
package dlss_pkg;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_SHELL = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_CONST = 1'b1;

	// sqrt(3)/2 in Q0.24 and 1/(4*pi) in Q0.32
	localparam logic [23:0] SQRT3_HALF_Q24  = 24'd14529495;
	localparam logic [28:0] INV_FOUR_PI_Q32 = 29'd341782638;

	localparam int MUL_W = 34;

	typedef struct packed {
		logic              req_type;
		logic [5:0]        atom_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] moment;
		logic [3:0]        shell_l;
		logic [3:0]        shell_k;
	} req_t;

	typedef struct packed {
		logic signed [63:0] shell_sum;
		logic signed [63:0] running_total;
		logic signed [63:0] total_over_four_pi;
		logic               coincident_flag;
		logic               overflow_flag;
	} res_t;

endpackage

[src/dlss_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlss_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module dlss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/dipolar_lattice_shell_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipolar_lattice_shell_sum: dipole-dipole lattice sum over hexagonal shells
// A load transaction stores one atom (position, moment) in a slot. A shell
// transaction (l,k) sums the pairwise dipole term over all atom pairs with the
// lattice offset of that shell, weights it and returns the shell sum, the
// running total and the total over 4*pi (signed Q32.32) with two flags.
// Only shell transactions give a result; loads give none.
// The block takes one transaction at a time: req_stall is high from the first
// cycle of a shell until its result is in the output register. A shell runs
// setup and loop control over n*n pairs; each pair takes normalise steps and
// up to |x| scale steps (x = 7 - 3*shift), the second division and the scale
// steps being skipped when the product is zero, while a coincident pair and a
// skipped self pair end early; the pair work uses the one-bit-per-cycle divider
// and root unit and the single shared 34x34 multiplier; a finish step follows.
// The result waits in res until taken; loads are still accepted meanwhile,
// but a following shell holds its result until the previous one has left.
// Reset clears the sequencer, the registers (atom_count 1, lattice 1.0) and
// the running total; atom stores are undefined until loaded.
// ----------------------------------------------------------------------------
module dipolar_lattice_shell_sum
	import dlss_pkg::*;
#(
	parameter int MAX_ATOMS = 64,
	parameter int MAX_SHELL = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam int NW = ($clog2(MAX_ATOMS + 1) > 7) ? $clog2(MAX_ATOMS + 1) : 7;
	localparam int IW = ((AW > 6) ? AW : 6) + 1;
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef enum logic [17:0] {
		ST_IDLE  = 18'h00001,
		ST_SETUP = 18'h00002,
		ST_ILOOP = 18'h00004,
		ST_LATI  = 18'h00008,
		ST_JLOOP = 18'h00010,
		ST_DIFF  = 18'h00020,
		ST_NORM  = 18'h00040,
		ST_SQ    = 18'h00080,
		ST_SQRT  = 18'h00100,
		ST_DMUL  = 18'h00200,
		ST_DIV1  = 18'h00400,
		ST_PMUL  = 18'h00800,
		ST_PCHK  = 18'h01000,
		ST_DIV2  = 18'h02000,
		ST_SCALE = 18'h04000,
		ST_ACC   = 18'h08000,
		ST_FINAL = 18'h10000,
		ST_DONE  = 18'h20000
	} state_t;

	state_t state_q;
	logic [6:0] cnt_q;

	logic [6:0]  atom_count_q;
	logic [30:0] lattice_q;
	logic signed [63:0] total_q;

	logic [3:0]    l_q, k_q;
	logic [NW-1:0] n_q, i_q, j_q;
	logic [34:0]   la_q, ka_q;
	logic signed [39:0] ox_q, oy_q;
	logic signed [31:0] xi_q, yi_q, zi_q;
	logic signed [15:0] mi_q, mj_q;
	logic [39:0]   ux_q, uy_q, uz_q;
	logic signed [6:0] sh_q;
	logic          mneg_q, nneg_q, neg_q;
	logic [59:0]   xx_q, yy_q, zz_q;
	logic [30:0]   mm_q;
	logic [31:0]   r2h_q;
	logic [61:0]   nmag_q;
	logic [63:0]   sv_q, sr_q, sb_q;
	logic [63:0]   d_q;
	logic [63:0]   dv_rem_q, dv_quo_q, dv_den_q;
	logic [6:0]    sc_q;
	logic          scl_q;
	logic signed [63:0] term_q, s_q, f4p_q;
	logic [63:0]   lop_q;
	logic          coinc_q, ov_q;
	logic [67:0]   prod_q;
	res_t          res_q;
	logic          res_valid_q;

	logic [MUL_W-1:0] mul_a, mul_b;
	logic             req_acc;
	logic [IW-1:0]    load_idx;
	logic             load_we;
	logic [AW-1:0]    raddr;
	logic [31:0]      rd_x, rd_y, rd_z;
	logic [15:0]      rd_m;

	logic signed [39:0] dx, dy, dz;
	logic [39:0]   ax, ay, az, uor;
	logic [15:0]   mi_abs, mj_abs;
	logic [61:0]   r2;
	logic signed [62:0] nv;
	logic [63:0]   sq_t;
	logic [63:0]   rem_sh, rem_nx, quo_nx;
	logic          dv_ge;
	logic signed [8:0] sh9, x9;
	logic [58:0]   oy_sum;
	logic          w_one, w_four;
	logic signed [63:0] sw;
	logic          sw_ov;
	logic [64:0]   acc_r, tot_r;
	logic [63:0]   tmag, f4p_r;
	logic [3:0]    l_sat;
	logic [NW-1:0] n_sat;

	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
	                                        input logic signed [63:0] b);
		logic signed [63:0] sum;
		logic ovf;
		sum = a + b;
		ovf = (a[63] == b[63]) && (sum[63] != a[63]);
		if (ovf) begin
			sum = a[63] ? S64_MIN : S64_MAX;
		end
		return {ovf, sum};
	endfunction

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign load_idx = IW'(req.atom_index);
	assign load_we  = req_acc && (req.req_type == REQ_LOAD) && (load_idx < IW'(MAX_ATOMS));
	assign raddr    = (state_q == ST_ILOOP) ? i_q[AW-1:0] : j_q[AW-1:0];

	dlss_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_ram_x (
		.clk(clk), .we(load_we), .waddr(load_idx[AW-1:0]), .wdata(req.pos_x),
		.raddr(raddr), .rdata(rd_x)
	);
	dlss_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_ram_y (
		.clk(clk), .we(load_we), .waddr(load_idx[AW-1:0]), .wdata(req.pos_y),
		.raddr(raddr), .rdata(rd_y)
	);
	dlss_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_ram_z (
		.clk(clk), .we(load_we), .waddr(load_idx[AW-1:0]), .wdata(req.pos_z),
		.raddr(raddr), .rdata(rd_z)
	);
	dlss_ram #(.WIDTH(16), .DEPTH(MAX_ATOMS)) u_ram_m (
		.clk(clk), .we(load_we), .waddr(load_idx[AW-1:0]), .wdata(req.moment),
		.raddr(raddr), .rdata(rd_m)
	);

	// shell index saturation and atom count clamp
	assign l_sat = (8'(req.shell_l) > 8'(MAX_SHELL)) ? 4'(MAX_SHELL) : req.shell_l;
	assign n_sat = (NW'(atom_count_q) > NW'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : NW'(atom_count_q);

	// pair separation in units of 2^-17
	always_comb begin
		dx  = (({{8{xi_q[31]}}, xi_q} - {{8{rd_x[31]}}, rd_x}) <<< 1) + ox_q;
		dy  = (({{8{yi_q[31]}}, yi_q} - {{8{rd_y[31]}}, rd_y}) <<< 1) + oy_q;
		dz  = (({{8{zi_q[31]}}, zi_q} - {{8{rd_z[31]}}, rd_z}) <<< 1);
		ax  = dx[39] ? 40'(-dx) : 40'(dx);
		ay  = dy[39] ? 40'(-dy) : 40'(dy);
		az  = dz[39] ? 40'(-dz) : 40'(dz);
		uor = ux_q | uy_q | uz_q;
		mi_abs = mi_q[15] ? 16'(-mi_q) : 16'(mi_q);
		mj_abs = mj_q[15] ? 16'(-mj_q) : 16'(mj_q);
		r2  = 62'(xx_q) + 62'(yy_q) + 62'(zz_q);
		nv  = $signed({2'b00, zz_q, 1'b0}) - $signed({3'b000, xx_q})
		      - $signed({3'b000, yy_q});
		sq_t = sr_q + sb_q;
		sh9 = 9'(sh_q);
		x9  = 9'sd7 - (sh9 + (sh9 <<< 1));
		oy_sum = prod_q[58:0] + 59'(1 << 22);
	end

	// shared restoring divider step, also used to extend the quotient
	always_comb begin
		rem_sh = {dv_rem_q[62:0], dv_quo_q[63]};
		dv_ge  = (rem_sh >= dv_den_q);
		rem_nx = dv_ge ? (rem_sh - dv_den_q) : rem_sh;
		quo_nx = {dv_quo_q[62:0], dv_ge};
	end

	// weighting, running total and 1/(4*pi) scaling
	always_comb begin
		w_one  = (l_q == 4'd0);
		w_four = (k_q == 4'd0) || (k_q == l_q);
		sw     = s_q;
		sw_ov  = 1'b0;
		if (!w_one) begin
			if (w_four) begin
				if ((s_q[63:61] != 3'b000) && (s_q[63:61] != 3'b111)) begin
					sw_ov = 1'b1;
					sw    = s_q[63] ? S64_MIN : S64_MAX;
				end else begin
					sw = s_q <<< 2;
				end
			end else begin
				if ((s_q[63:60] != 4'b0000) && (s_q[63:60] != 4'b1111)) begin
					sw_ov = 1'b1;
					sw    = s_q[63] ? S64_MIN : S64_MAX;
				end else begin
					sw = s_q <<< 3;
				end
			end
		end
		tot_r = w_one ? {1'b0, sw} : sat_add(total_q, sw);
		acc_r = sat_add(s_q, term_q);
		tmag  = total_q[63] ? (~total_q + 64'd1) : total_q;
		f4p_r = prod_q[63:0] + ((lop_q + 64'h8000_0000) >> 32);
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SETUP: begin
				case (cnt_q)
					7'd0: begin mul_a = MUL_W'(l_q);  mul_b = MUL_W'(lattice_q); end
					7'd1: begin mul_a = MUL_W'(k_q);  mul_b = MUL_W'(lattice_q); end
					7'd2: begin mul_a = MUL_W'(k_q);  mul_b = MUL_W'(SQRT3_HALF_Q24); end
					7'd3: begin mul_a = MUL_W'(lattice_q); mul_b = prod_q[MUL_W-1:0]; end
					default: ;
				endcase
			end
			ST_SQ: begin
				case (cnt_q)
					7'd0: begin mul_a = ux_q[MUL_W-1:0]; mul_b = ux_q[MUL_W-1:0]; end
					7'd1: begin mul_a = uy_q[MUL_W-1:0]; mul_b = uy_q[MUL_W-1:0]; end
					7'd2: begin mul_a = uz_q[MUL_W-1:0]; mul_b = uz_q[MUL_W-1:0]; end
					7'd3: begin mul_a = MUL_W'(mi_abs); mul_b = MUL_W'(mj_abs); end
					default: ;
				endcase
			end
			ST_DMUL: begin
				mul_a = MUL_W'(r2h_q);
				mul_b = sr_q[MUL_W-1:0];
			end
			ST_PMUL: begin
				mul_a = MUL_W'(mm_q);
				mul_b = dv_quo_q[MUL_W-1:0];
			end
			ST_FINAL: begin
				case (cnt_q)
					7'd1: begin mul_a = MUL_W'(tmag[31:0]);  mul_b = MUL_W'(INV_FOUR_PI_Q32); end
					7'd2: begin mul_a = MUL_W'(tmag[63:32]); mul_b = MUL_W'(INV_FOUR_PI_Q32); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= 7'd1;
			lattice_q    <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATOM_COUNT:    atom_count_q <= cfg_data[6:0];
				CFG_LATTICE_CONST: lattice_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			coinc_q     <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (req.req_type == REQ_SHELL)) begin
						l_q     <= l_sat;
						k_q     <= (req.shell_k > l_sat) ? l_sat : req.shell_k;
						n_q     <= n_sat;
						s_q     <= '0;
						coinc_q <= 1'b0;
						ov_q    <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd1) la_q <= prod_q[34:0];
					if (cnt_q == 7'd2) ka_q <= prod_q[34:0];
					if (cnt_q == 7'd4) begin
						ox_q    <= $signed({4'b0, la_q, 1'b0}) - $signed({5'b0, ka_q});
						oy_q    <= $signed({4'b0, oy_sum[58:23]});
						i_q     <= '0;
						state_q <= ST_ILOOP;
					end
				end
				ST_ILOOP: begin
					state_q <= (i_q >= n_q) ? ST_FINAL : ST_LATI;
					cnt_q   <= '0;
				end
				ST_LATI: begin
					xi_q    <= rd_x;
					yi_q    <= rd_y;
					zi_q    <= rd_z;
					mi_q    <= rd_m;
					j_q     <= '0;
					state_q <= ST_JLOOP;
				end
				ST_JLOOP: begin
					if (j_q >= n_q) begin
						i_q     <= i_q + NW'(1);
						state_q <= ST_ILOOP;
					end else if ((l_q == 4'd0) && (i_q == j_q)) begin
						j_q <= j_q + NW'(1);
					end else begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					ux_q   <= ax;
					uy_q   <= ay;
					uz_q   <= az;
					mj_q   <= rd_m;
					mneg_q <= mi_q[15] ^ rd_m[15];
					sh_q   <= '0;
					if ((ax | ay | az) == 40'd0) begin
						coinc_q <= 1'b1;
						j_q     <= j_q + NW'(1);
						state_q <= ST_JLOOP;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (uor[39:30] != 10'd0) begin
						ux_q <= ux_q >> 1;
						uy_q <= uy_q >> 1;
						uz_q <= uz_q >> 1;
						sh_q <= sh_q + 7'sd1;
					end else if (!uor[29]) begin
						ux_q <= ux_q << 1;
						uy_q <= uy_q << 1;
						uz_q <= uz_q << 1;
						sh_q <= sh_q - 7'sd1;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd1) xx_q <= prod_q[59:0];
					if (cnt_q == 7'd2) yy_q <= prod_q[59:0];
					if (cnt_q == 7'd3) zz_q <= prod_q[59:0];
					if (cnt_q == 7'd4) begin
						mm_q    <= prod_q[30:0];
						r2h_q   <= r2[61:30];
						nneg_q  <= nv[62];
						nmag_q  <= nv[62] ? 62'(-nv) : 62'(nv);
						sv_q    <= 64'(r2);
						sr_q    <= '0;
						sb_q    <= 64'h4000_0000_0000_0000;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sv_q >= sq_t) begin
						sv_q <= sv_q - sq_t;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
					if (sb_q == 64'd1) state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					dv_rem_q <= '0;
					dv_quo_q <= 64'(nmag_q);
					dv_den_q <= 64'(r2h_q);
					cnt_q    <= '0;
					state_q  <= ST_DIV1;
				end
				ST_DIV1: begin
					if (cnt_q == 7'd0) d_q <= prod_q[63:0];
					dv_rem_q <= rem_nx;
					dv_quo_q <= quo_nx;
					cnt_q    <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					if (prod_q[62:0] == 63'd0) begin
						term_q  <= '0;
						state_q <= ST_ACC;
					end else begin
						dv_rem_q <= '0;
						dv_quo_q <= 64'(prod_q[62:0]);
						dv_den_q <= d_q;
						cnt_q    <= '0;
						state_q  <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					dv_rem_q <= rem_nx;
					dv_quo_q <= quo_nx;
					cnt_q    <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						scl_q   <= !x9[8];
						sc_q    <= x9[8] ? 7'(-x9) : 7'(x9);
						neg_q   <= nneg_q ^ mneg_q;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (sc_q == 7'd0) begin
						term_q  <= neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q);
						state_q <= ST_ACC;
					end else if (scl_q) begin
						if (dv_quo_q[63] || dv_quo_q[62]) begin
							ov_q    <= 1'b1;
							term_q  <= neg_q ? S64_MIN : S64_MAX;
							state_q <= ST_ACC;
						end else begin
							dv_rem_q <= rem_nx;
							dv_quo_q <= quo_nx;
							sc_q     <= sc_q - 7'd1;
						end
					end else begin
						dv_quo_q <= dv_quo_q >> 1;
						sc_q     <= sc_q - 7'd1;
					end
				end
				ST_ACC: begin
					s_q     <= acc_r[63:0];
					if (acc_r[64]) ov_q <= 1'b1;
					j_q     <= j_q + NW'(1);
					state_q <= ST_JLOOP;
				end
				ST_FINAL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd0) begin
						s_q     <= sw;
						total_q <= tot_r[63:0];
						if (sw_ov || tot_r[64]) ov_q <= 1'b1;
					end
					if (cnt_q == 7'd2) lop_q <= prod_q[63:0];
					if (cnt_q == 7'd3) begin
						f4p_q   <= total_q[63] ? -$signed(f4p_r) : $signed(f4p_r);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q.shell_sum          <= s_q;
						res_q.running_total      <= total_q;
						res_q.total_over_four_pi <= f4p_q;
						res_q.coincident_flag    <= coinc_q;
						res_q.overflow_flag      <= ov_q;
						res_valid_q              <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the completion state");

	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF) |-> ((i_q < n_q) && (j_q < n_q)))
		else $error("pair index beyond atom count");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> (uor[39:29] == 11'd1))
		else $error("normalised separation out of range");

	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DMUL) |-> (sr_q[63:31] == 33'd0))
		else $error("square root wider than 31 bits");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of dipolar_lattice_shell_sum
// A queue of pending operations (atom loads, shell requests, register writes,
// drains, idling modes, receiver hold-offs) feeds a clocked driver. Each
// accepted shell transaction is predicted in the testbench's own fixed-point
// model and the result is checked field by field by a clocked monitor.
// ----------------------------------------------------------------------------
module tb_top;
	import dlss_pkg::*;

	typedef enum int {OP_REQ, OP_CFG, OP_DRAIN, OP_MODE, OP_HOLD} op_kind_t;

	typedef struct {
		op_kind_t              kind;
		req_t                  r;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		int                    s_idle;
		int                    r_stall;
	} op_t;

	localparam int  HOLD_CYCLES = 20000;
	localparam int  WATCHDOG    = 4000000;
	localparam longint I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  res_valid;
	logic                  res_stall;
	res_t                  res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	op_t    pending_q[$];
	res_t   shell_expect_q[$];
	longint atom_x[64], atom_y[64], atom_z[64], atom_m[64];
	longint total_model;
	longint n_atoms_model;
	longint lattice_model;
	int     send_idle, recv_stall;
	int     cooldown;
	int     hold_seq, hold_seen, hold_cnt;
	int     quiet_cycles;
	int     errors;
	bit     stim_done;

	dipolar_lattice_shell_sum DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic bit [63:0] mag(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat_sum(longint a, longint b, inout bit ov);
		if (b > 0 && a > I64_MAX - b) begin
			ov = 1;
			return I64_MAX;
		end
		if (b < 0 && a < I64_MIN - b) begin
			ov = 1;
			return I64_MIN;
		end
		return a + b;
	endfunction

	function automatic longint dipole_term(longint dx, longint dy, longint dz, longint mm,
			inout bit coinc, inout bit ov);
		bit [63:0] ux, uy, uz, m, r2, rt, r2h, d, nq, p, q, rem;
		int b, sh, x;
		longint n;
		bit neg;
		ux = mag(dx);
		uy = mag(dy);
		uz = mag(dz);
		m = ux;
		if (uy > m) m = uy;
		if (uz > m) m = uz;
		if (m == 0) begin
			coinc = 1;
			return 0;
		end
		b = 0;
		while (b < 63 && (m >> b) != 0)
			b++;
		sh = b - 30;
		if (sh > 0) begin
			ux >>= sh; uy >>= sh; uz >>= sh;
		end else begin
			ux <<= -sh; uy <<= -sh; uz <<= -sh;
		end
		r2 = ux * ux + uy * uy + uz * uz;
		n = longint'(64'd2 * uz * uz) - longint'(ux * ux) - longint'(uy * uy);
		rt = int_sqrt(r2);
		r2h = r2 >> 30;
		d = r2h * rt;
		nq = mag(n) / r2h;
		neg = (n < 0) != (mm < 0);
		p = mag(mm) * nq;
		if (p == 0)
			return 0;
		x = 7 - 3 * sh;
		q = p / d;
		rem = p % d;
		if (x < 0) begin
			q = (-x >= 64) ? 64'd0 : (q >> (-x));
		end else begin
			for (int i = 0; i < x; i++) begin
				if (q > 64'h3FFF_FFFF_FFFF_FFFF) begin
					ov = 1;
					return neg ? I64_MIN : I64_MAX;
				end
				q <<= 1;
				rem <<= 1;
				if (rem >= d) begin
					rem = rem - d;
					q = q + 64'd1;
				end
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint quarter_pi_scale(longint t);
		bit [63:0] mg, hi, lo, r;
		mg = mag(t);
		hi = mg >> 32;
		lo = mg & 64'hFFFF_FFFF;
		r = hi * 64'(INV_FOUR_PI_Q32)
			+ ((lo * 64'(INV_FOUR_PI_Q32) + 64'h8000_0000) >> 32);
		return t < 0 ? -longint'(r) : longint'(r);
	endfunction

	// shell transaction: weighted pair sum and running total
	function automatic res_t shell_sum_predict(req_t r);
		longint l, k, n, a, ox2, oy, s, w, dx, dy, dz, t;
		bit coinc, ov;
		res_t e;
		l = longint'(r.shell_l);
		k = longint'(r.shell_k);
		if (k > l) k = l;
		n = n_atoms_model > 64 ? 64 : n_atoms_model;
		a = lattice_model;
		ox2 = 2 * l * a - k * a;
		oy = (k * a * longint'(SQRT3_HALF_Q24) + (longint'(1) << 22)) >>> 23;
		s = 0;
		coinc = 0;
		ov = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (l == 0 && i == j)
					continue;
				dx = 2 * (atom_x[i] - atom_x[j]) + ox2;
				dy = 2 * (atom_y[i] - atom_y[j]) + oy;
				dz = 2 * (atom_z[i] - atom_z[j]);
				t = dipole_term(dx, dy, dz, atom_m[i] * atom_m[j], coinc, ov);
				s = sat_sum(s, t, ov);
			end
		end
		w = (l == 0) ? 1 : ((k == 0 || k == l) ? 4 : 8);
		if (s > I64_MAX / w) begin
			ov = 1;
			s = I64_MAX;
		end else if (s < I64_MIN / w) begin
			ov = 1;
			s = I64_MIN;
		end else begin
			s = s * w;
		end
		total_model = (l == 0) ? s : sat_sum(total_model, s, ov);
		e.shell_sum = s;
		e.running_total = total_model;
		e.total_over_four_pi = quarter_pi_scale(total_model);
		e.coincident_flag = coinc;
		e.overflow_flag = ov;
		return e;
	endfunction

	task automatic add_load(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] m);
		op_t o;
		o.kind = OP_REQ;
		o.r = '0;
		o.r.req_type = REQ_LOAD;
		o.r.atom_index = 6'(idx);
		o.r.pos_x = x;
		o.r.pos_y = y;
		o.r.pos_z = z;
		o.r.moment = m;
		// unused shell bits carry noise
		o.r.shell_l = 4'($urandom);
		o.r.shell_k = 4'($urandom);
		pending_q.insert(pending_q.size(), o);
	endtask

	task automatic add_shell(int l, int k);
		op_t o;
		o.kind = OP_REQ;
		o.r = '0;
		o.r.req_type = REQ_SHELL;
		o.r.atom_index = 6'($urandom);
		o.r.pos_x = $urandom;
		o.r.pos_y = $urandom;
		o.r.pos_z = $urandom;
		o.r.moment = 16'($urandom);
		o.r.shell_l = 4'(l);
		o.r.shell_k = 4'(k);
		pending_q.insert(pending_q.size(), o);
	endtask

	task automatic add_simple(op_kind_t kind);
		op_t o;
		o = '{kind: kind, default: 0};
		pending_q.insert(pending_q.size(), o);
	endtask

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		op_t o;
		add_simple(OP_DRAIN);
		o = '{kind: OP_CFG, default: 0};
		o.idx = idx;
		o.data = CFG_DATA_W'(data);
		pending_q.insert(pending_q.size(), o);
	endtask

	task automatic add_mode(int s_idle, int r_stall);
		op_t o;
		o = '{kind: OP_MODE, default: 0};
		o.s_idle = s_idle;
		o.r_stall = r_stall;
		pending_q.insert(pending_q.size(), o);
	endtask

	task automatic add_random_phase(int s_idle, int r_stall, int count, bit with_hold);
		int cur_l;
		add_cfg(CFG_ATOM_COUNT, $urandom_range(1, 4));
		add_cfg(CFG_LATTICE_CONST, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
		add_mode(s_idle, r_stall);
		if (with_hold)
			add_simple(OP_HOLD);
		cur_l = 0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 4) begin
				if ($urandom_range(1))
					add_load($urandom_range(7), $urandom, $urandom, $urandom,
						16'($urandom));
				else
					add_load($urandom_range(7), $urandom_range(1 << 18) - (1 << 17),
						$urandom_range(1 << 18) - (1 << 17),
						$urandom_range(1 << 18) - (1 << 17), 16'($urandom));
			end else begin
				if ($urandom_range(9) == 0)
					add_shell($urandom, $urandom);
				else
					add_shell(cur_l, $urandom_range(9) == 0 ? $urandom_range(15)
						: $urandom_range(cur_l));
				cur_l = ($urandom_range(7) == 0 || cur_l == 15) ? 0 : cur_l + 1;
			end
			if (i == count / 2)
				add_simple(OP_DRAIN);
		end
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		errors = 0;
		stim_done = 0;
		for (int i = 0; i < 64; i++)
			add_load(i, $urandom, $urandom, $urandom, 16'($urandom));

		// directed
		add_load(0, 0, 0, 0, 16'sh8000);
		add_load(1, 1, 0, 0, 16'sh8000);
		add_cfg(CFG_ATOM_COUNT, 2);
		add_shell(0, 0);
		add_load(1, 0, 0, 0, 16'sh7FFF);
		add_shell(0, 0);
		add_shell(1, 0);
		add_load(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh7FFF);
		add_load(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'sh8000);
		add_shell(1, 1);
		add_shell(2, 1);
		add_shell(3, 7);
		add_shell(15, 15);
		add_cfg(CFG_LATTICE_CONST, 0);
		add_shell(1, 0);
		add_cfg(CFG_LATTICE_CONST, 32'h7FFF_FFFF);
		add_shell(0, 0);
		add_shell(15, 8);
		add_cfg(CFG_ATOM_COUNT, 1);
		add_shell(0, 0);
		add_shell(4, 2);

		add_random_phase(0, 0, 10, 1);
		add_random_phase(84, 0, 6, 0);
		add_random_phase(0, 84, 6, 0);
		add_random_phase(7, 7, 8, 0);

		// atom count above the store size acts as a full store
		add_mode(0, 0);
		add_cfg(CFG_ATOM_COUNT, 100);
		add_cfg(CFG_LATTICE_CONST, 65536);
		add_shell(0, 0);
		add_simple(OP_DRAIN);

		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (stim_done);
		repeat (50) @(posedge clk);
		if (errors == 0 && shell_expect_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic v;
		logic we;
		op_t o;
		if (!arst_n) begin
			req_valid <= 0;
			req <= '0;
			cfg_we <= 0;
			cfg_index <= '0;
			cfg_data <= '0;
			cooldown = 0;
			hold_seq <= 0;
			send_idle = 0;
			recv_stall = 0;
			total_model = 0;
			n_atoms_model = 1;
			lattice_model = 65536;
			for (int i = 0; i < 64; i++) begin
				atom_x[i] = 0; atom_y[i] = 0; atom_z[i] = 0; atom_m[i] = 0;
			end
		end else begin
			v = req_valid;
			we = 0;
			if (v && !req_stall) begin
				if (req.req_type == REQ_SHELL) begin
					shell_expect_q.insert(shell_expect_q.size(), shell_sum_predict(req));
				end else begin
					atom_x[req.atom_index] = longint'(req.pos_x);
					atom_y[req.atom_index] = longint'(req.pos_y);
					atom_z[req.atom_index] = longint'(req.pos_z);
					atom_m[req.atom_index] = longint'(req.moment);
				end
				v = 0;
			end
			if (!v) begin
				if (cooldown > 0) begin
					cooldown--;
				end else if (pending_q.size() == 0) begin
					if (shell_expect_q.size() == 0)
						stim_done = 1;
				end else begin
					o = pending_q[0];
					case (o.kind)
						OP_REQ: begin
							if ($urandom_range(99) >= send_idle) begin
								v = 1;
								req <= o.r;
								void'(pending_q.pop_front());
							end
						end
						OP_CFG: begin
							we = 1;
							cfg_index <= o.idx;
							cfg_data <= o.data;
							if (o.idx == CFG_ATOM_COUNT)
								n_atoms_model = longint'(o.data & 31'h7F);
							else
								lattice_model = longint'(o.data);
							void'(pending_q.pop_front());
						end
						OP_DRAIN: begin
							if (shell_expect_q.size() == 0) begin
								cooldown = 30;
								void'(pending_q.pop_front());
							end
						end
						OP_MODE: begin
							send_idle = o.s_idle;
							recv_stall = o.r_stall;
							void'(pending_q.pop_front());
						end
						OP_HOLD: begin
							hold_seq <= hold_seq + 1;
							void'(pending_q.pop_front());
						end
						default: ;
					endcase
				end
			end
			req_valid <= v;
			cfg_we <= we;
		end
	end

	// monitor and receiver stalling
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			res_stall <= 0;
			hold_seen = 0;
			hold_cnt = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (shell_expect_q.size() == 0) begin
					$error("result with no transaction pending");
					errors++;
				end else begin
					e = shell_expect_q.pop_front();
					if (res.shell_sum !== e.shell_sum) begin
						$error("shell_sum exp %0d got %0d", e.shell_sum, res.shell_sum);
						errors++;
					end
					if (res.running_total !== e.running_total) begin
						$error("running_total exp %0d got %0d", e.running_total,
							res.running_total);
						errors++;
					end
					if (res.total_over_four_pi !== e.total_over_four_pi) begin
						$error("total_over_four_pi exp %0d got %0d", e.total_over_four_pi,
							res.total_over_four_pi);
						errors++;
					end
					if (res.coincident_flag !== e.coincident_flag) begin
						$error("coincident_flag exp %0b got %0b", e.coincident_flag,
							res.coincident_flag);
						errors++;
					end
					if (res.overflow_flag !== e.overflow_flag) begin
						$error("overflow_flag exp %0b got %0b", e.overflow_flag,
							res.overflow_flag);
						errors++;
					end
				end
			end
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_stall <= 1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_stall);
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
